// File: hdl/rcpg_pkg.sv
`default_nettype none
package rcpg_pkg;

  localparam int COORD_W = 24;
  localparam int ALT_W   = 25;
  localparam int CODE_W  = 16;
  localparam int HFOV_W  = 17;
  localparam int VFOV_W  = 16;
  localparam int RNG_W   = 24;
  localparam int BRG_W   = 17;
  localparam int ELV_W   = 16;

  // square root: 64-bit radicand, one root bit per stage
  localparam int SQ_IN_W  = 64;
  localparam int SQ_OUT_W = 32;
  localparam int SQ_REM_W = 35;

  // CORDIC datapath
  localparam int CV_W   = 36;
  localparam int ACC_W  = 26;
  localparam int ANG_W  = 22;
  localparam int TAB_N  = 24;
  localparam int TAB_IW = 5;

  localparam logic [ANG_W-1:0] ATAN_STEP [0:TAB_N-1] = '{
    22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
    22'd41718,   22'd20860,   22'd10430,  22'd5215,   22'd2608,   22'd1304,
    22'd652,     22'd326,     22'd163,    22'd81,     22'd41,     22'd20,
    22'd10,      22'd5,       22'd3,      22'd1,      22'd1,      22'd0
  };

  localparam logic signed [ACC_W-1:0] QUARTER_TURN = 26'sd4194304;

  typedef enum logic [1:0] {
    CFG_HFOV  = 2'd0,
    CFG_VFOV  = 2'd1,
    CFG_RLIM  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_OUT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic signed [CV_W-1:0]  x;
    logic signed [CV_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
  } cv_t;

  function automatic sq_t sq_step(sq_t s, logic [1:0] pair);
    logic [SQ_REM_W-1:0] cand;
    logic [SQ_REM_W-1:0] trial;
    sq_t r;
    cand  = {s.rem[SQ_REM_W-3:0], pair};
    trial = {1'b0, s.root, 2'b01};
    if (cand >= trial) begin
      r.rem  = cand - trial;
      r.root = {s.root[SQ_OUT_W-2:0], 1'b1};
    end else begin
      r.rem  = cand;
      r.root = {s.root[SQ_OUT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // one vectoring micro-rotation; >>> floors like the arithmetic shift it models
  function automatic cv_t cordic_step(cv_t v, logic [TAB_IW-1:0] sh, logic [ANG_W-1:0] ang);
    logic signed [CV_W-1:0]  dx;
    logic signed [CV_W-1:0]  dy;
    logic signed [ACC_W-1:0] da;
    cv_t r;
    dx = v.y >>> sh;
    dy = v.x >>> sh;
    da = $signed({{(ACC_W-ANG_W){1'b0}}, ang});
    if (!v.y[CV_W-1]) begin
      r.x   = v.x + dx;
      r.y   = v.y - dy;
      r.acc = v.acc + da;
    end else begin
      r.x   = v.x - dx;
      r.y   = v.y + dy;
      r.acc = v.acc - da;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/rcpg_in_if.sv
`default_nettype none
interface rcpg_in_if
  import rcpg_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] rel_x;
  logic signed [COORD_W-1:0] rel_y;
  logic signed [COORD_W-1:0] rel_z;
  logic signed [COORD_W-1:0] sensor_altitude;
  logic [CODE_W-1:0]         transponder_code;
  modport source (output valid, rel_x, rel_y, rel_z, sensor_altitude, transponder_code,
                  input ready);
  modport sink (input valid, rel_x, rel_y, rel_z, sensor_altitude, transponder_code,
                output ready);
endinterface
`default_nettype wire

// File: hdl/rcpg_out_if.sv
`default_nettype none
interface rcpg_out_if
  import rcpg_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [RNG_W-1:0]        target_range;
  logic signed [BRG_W-1:0] target_bearing;
  logic signed [ALT_W-1:0] target_altitude;
  logic [CODE_W-1:0]       contact_code;
  modport source (output valid, target_range, target_bearing, target_altitude, contact_code,
                  input ready);
  modport sink (input valid, target_range, target_bearing, target_altitude, contact_code,
                output ready);
endinterface
`default_nettype wire

// File: hdl/rcpg_sqrt2.sv
`default_nettype none
// Two floor square roots side by side, one root bit per stage.
module rcpg_sqrt2
  import rcpg_pkg::*;
#(
  parameter int SIDE_W = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [SQ_IN_W-1:0]  in_a,
  input  wire logic [SQ_IN_W-1:0]  in_b,
  input  wire logic [SIDE_W-1:0]   in_side,
  output logic                     out_valid,
  output logic [SQ_OUT_W-1:0]      out_a,
  output logic [SQ_OUT_W-1:0]      out_b,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int N = SQ_OUT_W;

  logic [N-1:0]         vld_r;
  sq_t                  a_r    [N];
  sq_t                  b_r    [N];
  logic [SQ_IN_W-1:0]   va_r   [N];
  logic [SQ_IN_W-1:0]   vb_r   [N];
  logic [SIDE_W-1:0]    side_r [N];
  sq_t                  a_nxt  [N];
  sq_t                  b_nxt  [N];

  always_comb begin
    a_nxt[0] = sq_step('0, in_a[SQ_IN_W-1 -: 2]);
    b_nxt[0] = sq_step('0, in_b[SQ_IN_W-1 -: 2]);
    for (int i = 1; i < N; i++) begin
      a_nxt[i] = sq_step(a_r[i-1], va_r[i-1][SQ_IN_W-1 -: 2]);
      b_nxt[i] = sq_step(b_r[i-1], vb_r[i-1][SQ_IN_W-1 -: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_valid};
    end
  end

  // radicands shift left two bits a stage so the next pair sits on top
  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0]    <= a_nxt[0];
      b_r[0]    <= b_nxt[0];
      va_r[0]   <= {in_a[SQ_IN_W-3:0], 2'b00};
      vb_r[0]   <= {in_b[SQ_IN_W-3:0], 2'b00};
      side_r[0] <= in_side;
      for (int i = 1; i < N; i++) begin
        a_r[i]    <= a_nxt[i];
        b_r[i]    <= b_nxt[i];
        va_r[i]   <= {va_r[i-1][SQ_IN_W-3:0], 2'b00};
        vb_r[i]   <= {vb_r[i-1][SQ_IN_W-3:0], 2'b00};
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_a     = a_r[N-1].root;
  assign out_b     = b_r[N-1].root;
  assign out_side  = side_r[N-1];

endmodule
`default_nettype wire

// File: hdl/rcpg_cordic.sv
`default_nettype none
// Two vectoring CORDIC pipelines in lockstep, one micro-rotation per stage.
module rcpg_cordic
  import rcpg_pkg::*;
#(
  parameter int STAGES = 16,
  parameter int SIDE_W = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire cv_t                in_b,
  input  wire cv_t                in_e,
  input  wire logic [SIDE_W-1:0]  in_side,
  output logic                    out_valid,
  output logic signed [ACC_W-1:0] out_b_acc,
  output logic signed [ACC_W-1:0] out_e_acc,
  output logic [SIDE_W-1:0]       out_side
);

  logic [STAGES-1:0] vld_r;
  cv_t               b_r    [STAGES];
  cv_t               e_r    [STAGES];
  logic [SIDE_W-1:0] side_r [STAGES];
  cv_t               b_nxt  [STAGES];
  cv_t               e_nxt  [STAGES];

  always_comb begin
    b_nxt[0] = cordic_step(in_b, '0, ATAN_STEP[0]);
    e_nxt[0] = cordic_step(in_e, '0, ATAN_STEP[0]);
    for (int i = 1; i < STAGES; i++) begin
      b_nxt[i] = cordic_step(b_r[i-1], TAB_IW'(i), ATAN_STEP[TAB_IW'(i)]);
      e_nxt[i] = cordic_step(e_r[i-1], TAB_IW'(i), ATAN_STEP[TAB_IW'(i)]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r[0]    <= b_nxt[0];
      e_r[0]    <= e_nxt[0];
      side_r[0] <= in_side;
      for (int i = 1; i < STAGES; i++) begin
        b_r[i]    <= b_nxt[i];
        e_r[i]    <= e_nxt[i];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_b_acc = b_r[STAGES-1].acc;
  assign out_e_acc = e_r[STAGES-1].acc;
  assign out_side  = side_r[STAGES-1];

endmodule
`default_nettype wire

// File: hdl/radar_contact_polar_gate_unit.sv
// Radar contact polar gate: turns a target offset (x, y, z) into range,
// bearing atan2(-y, x) and elevation, and emits a contact only when the target
// is inside both fields of view, at nonzero range and closer than the range
// limit. One item is taken every cycle unless the output stalls; each item
// passes the squares, sum, 32 square-root stages, CORDIC_STAGES rotation
// stages, rounding and gate/output registers. Items that fail the gate produce
// no result. The whole pipeline holds while a result waits on the output.
`default_nettype none
module radar_contact_polar_gate_unit
  import rcpg_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rcpg_in_if.sink          in_item,
  rcpg_out_if.source       out_item,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int SQ_SIDE_W = 3*CV_W + ACC_W + ALT_W + CODE_W;
  localparam int CD_SIDE_W = RNG_W + ALT_W + CODE_W;

  // configuration
  logic [HFOV_W-1:0] hfov_r;
  logic [VFOV_W-1:0] vfov_r;
  logic [RNG_W-1:0]  rlim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hfov_r <= 17'd65536;
      vfov_r <= 16'd32768;
      rlim_r <= 24'd2560000;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HFOV: hfov_r <= cfg_data[HFOV_W-1:0];
        CFG_VFOV: vfov_r <= cfg_data[VFOV_W-1:0];
        CFG_RLIM: rlim_r <= cfg_data[RNG_W-1:0];
        default:  ;
      endcase
    end
  end

  logic out_valid_r;
  logic en;
  assign en = !out_valid_r || out_item.ready;
  assign in_item.ready = en;

  // stage 1: squares
  logic                      p1_valid_r;
  logic signed [COORD_W-1:0] p1_x_r, p1_y_r, p1_z_r;
  logic signed [ALT_W-1:0]   p1_alt_r;
  logic [CODE_W-1:0]         p1_code_r;
  logic [2*COORD_W-1:0]      p1_x2_r, p1_y2_r, p1_z2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_x_r    <= in_item.rel_x;
      p1_y_r    <= in_item.rel_y;
      p1_z_r    <= in_item.rel_z;
      p1_alt_r  <= ALT_W'(in_item.sensor_altitude) + ALT_W'(in_item.rel_z);
      p1_code_r <= in_item.transponder_code;
      p1_x2_r   <= $unsigned((2*COORD_W)'(in_item.rel_x) * (2*COORD_W)'(in_item.rel_x));
      p1_y2_r   <= $unsigned((2*COORD_W)'(in_item.rel_y) * (2*COORD_W)'(in_item.rel_y));
      p1_z2_r   <= $unsigned((2*COORD_W)'(in_item.rel_z) * (2*COORD_W)'(in_item.rel_z));
    end
  end

  // stage 2: sums and bearing quadrant fold
  logic [2*COORD_W-1:0]  hsq;
  logic [2*COORD_W:0]    rsq;
  logic signed [CV_W-1:0] bx0, by0;
  cv_t                   brot_nxt;
  logic signed [CV_W-1:0] ez_nxt;

  always_comb begin
    hsq = p1_x2_r + p1_y2_r;
    rsq = {1'b0, hsq} + {1'b0, p1_z2_r};
    bx0 = {{(CV_W-COORD_W-8){p1_x_r[COORD_W-1]}}, p1_x_r, 8'd0};
    by0 = -{{(CV_W-COORD_W-8){p1_y_r[COORD_W-1]}}, p1_y_r, 8'd0};
    ez_nxt = {{(CV_W-COORD_W-8){p1_z_r[COORD_W-1]}}, p1_z_r, 8'd0};
    brot_nxt.x   = bx0;
    brot_nxt.y   = by0;
    brot_nxt.acc = '0;
    // left half plane: turn by a quarter so the CORDIC sees x >= 0
    if (bx0[CV_W-1]) begin
      if (!by0[CV_W-1]) begin
        brot_nxt.x   = by0;
        brot_nxt.y   = -bx0;
        brot_nxt.acc = QUARTER_TURN;
      end else begin
        brot_nxt.x   = -by0;
        brot_nxt.y   = bx0;
        brot_nxt.acc = -QUARTER_TURN;
      end
    end
  end

  logic                   p2_valid_r;
  logic [SQ_IN_W-1:0]     p2_hsq_r, p2_rsq_r;
  cv_t                    p2_b_r;
  logic signed [CV_W-1:0] p2_ez_r;
  logic signed [ALT_W-1:0] p2_alt_r;
  logic [CODE_W-1:0]      p2_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (en) begin
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_hsq_r  <= {hsq, 16'd0};
      p2_rsq_r  <= {{(SQ_IN_W-2*COORD_W-1){1'b0}}, rsq};
      p2_b_r    <= brot_nxt;
      p2_ez_r   <= ez_nxt;
      p2_alt_r  <= p1_alt_r;
      p2_code_r <= p1_code_r;
    end
  end

  // square roots: horizontal distance (scaled by 256) and range
  logic                  sq_valid;
  logic [SQ_OUT_W-1:0]   sq_h, sq_r;
  logic [SQ_SIDE_W-1:0]  sq_side;
  cv_t                   sq_b;
  logic signed [CV_W-1:0] sq_ez;
  logic signed [ALT_W-1:0] sq_alt;
  logic [CODE_W-1:0]     sq_code;

  rcpg_sqrt2 #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (p2_valid_r),
    .in_a     (p2_hsq_r),
    .in_b     (p2_rsq_r),
    .in_side  ({p2_b_r, p2_ez_r, p2_alt_r, p2_code_r}),
    .out_valid(sq_valid),
    .out_a    (sq_h),
    .out_b    (sq_r),
    .out_side (sq_side)
  );

  assign {sq_b, sq_ez, sq_alt, sq_code} = sq_side;

  cv_t e_in;
  always_comb begin
    e_in.x   = $signed({{(CV_W-SQ_OUT_W){1'b0}}, sq_h});
    e_in.y   = sq_ez;
    e_in.acc = '0;
  end

  logic                    cd_valid;
  logic signed [ACC_W-1:0] cd_b_acc, cd_e_acc;
  logic [CD_SIDE_W-1:0]    cd_side;
  logic [RNG_W-1:0]        cd_range;
  logic signed [ALT_W-1:0] cd_alt;
  logic [CODE_W-1:0]       cd_code;

  rcpg_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(CD_SIDE_W)) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sq_valid),
    .in_b     (sq_b),
    .in_e     (e_in),
    .in_side  ({sq_r[RNG_W-1:0], sq_alt, sq_code}),
    .out_valid(cd_valid),
    .out_b_acc(cd_b_acc),
    .out_e_acc(cd_e_acc),
    .out_side (cd_side)
  );

  assign {cd_range, cd_alt, cd_code} = cd_side;

  // stage 3: round to pi/32768 and clamp
  localparam int RND_W = ACC_W + 1 - 8;
  logic signed [ACC_W:0]   b_sum, e_sum;
  logic signed [RND_W-1:0] b_rnd, e_rnd;
  logic signed [BRG_W-1:0] brg_nxt;
  logic signed [ELV_W-1:0] elv_nxt;

  always_comb begin
    b_sum = $signed({cd_b_acc[ACC_W-1], cd_b_acc}) + 27'sd128;
    e_sum = $signed({cd_e_acc[ACC_W-1], cd_e_acc}) + 27'sd128;
    b_rnd = RND_W'(b_sum >>> 8);
    e_rnd = RND_W'(e_sum >>> 8);
    if (b_rnd > 19'sd32768)       brg_nxt = 17'sd32767 + 17'sd1;
    else if (b_rnd < -19'sd32768) brg_nxt = -17'sd32767 - 17'sd1;
    else                          brg_nxt = BRG_W'(b_rnd);
    if (e_rnd > 19'sd16384)       elv_nxt = 16'sd16384;
    else if (e_rnd < -19'sd16384) elv_nxt = -16'sd16384;
    else                          elv_nxt = ELV_W'(e_rnd);
  end

  logic                    p3_valid_r;
  logic signed [BRG_W-1:0] p3_brg_r;
  logic signed [ELV_W-1:0] p3_elv_r;
  logic [RNG_W-1:0]        p3_range_r;
  logic signed [ALT_W-1:0] p3_alt_r;
  logic [CODE_W-1:0]       p3_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
    end else if (en) begin
      p3_valid_r <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_brg_r   <= brg_nxt;
      p3_elv_r   <= elv_nxt;
      p3_range_r <= cd_range;
      p3_alt_r   <= cd_alt;
      p3_code_r  <= cd_code;
    end
  end

  // gate
  logic [BRG_W:0]   brg_twice;
  logic [ELV_W:0]   elv_twice;
  logic             pass;

  always_comb begin
    brg_twice = p3_brg_r[BRG_W-1] ? {(-p3_brg_r), 1'b0} : {p3_brg_r, 1'b0};
    elv_twice = p3_elv_r[ELV_W-1] ? {(-p3_elv_r), 1'b0} : {p3_elv_r, 1'b0};
    pass = (p3_range_r != '0)
        && (brg_twice < {1'b0, hfov_r})
        && (elv_twice < {1'b0, vfov_r})
        && (p3_range_r < rlim_r);
  end

  logic                    out_valid_nxt;
  logic [RNG_W-1:0]        out_range_r;
  logic signed [BRG_W-1:0] out_brg_r;
  logic signed [ALT_W-1:0] out_alt_r;
  logic [CODE_W-1:0]       out_code_r;

  assign out_valid_nxt = p3_valid_r && pass;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_range_r <= p3_range_r;
      out_brg_r   <= p3_brg_r;
      out_alt_r   <= p3_alt_r;
      out_code_r  <= p3_code_r;
    end
  end

  assign out_item.valid           = out_valid_r;
  assign out_item.target_range    = out_range_r;
  assign out_item.target_bearing  = out_brg_r;
  assign out_item.target_altitude = out_alt_r;
  assign out_item.contact_code    = out_code_r;

`ifndef NO_ASSERTIONS
  a_no_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_range_r != '0)
    else $error("contact with zero range");

  a_bearing_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_brg_r <= 17'sd32767 + 17'sd1) && (out_brg_r >= -17'sd32767 - 17'sd1))
    else $error("bearing out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item.ready |=> $stable(p3_valid_r) && $stable(p1_valid_r))
    else $error("pipeline moved during stall");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(p1_valid_r) |-> $past(in_item.valid && in_item.ready))
    else $error("stage one filled without an accepted item");
`endif

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none
module tb_top
  import rcpg_pkg::*;
();

  localparam int STAGES     = 16;
  localparam int LATENCY    = 36 + STAGES;
  localparam int STALL_MAX  = 20000;
  localparam int HOLD_LEN   = 400;
  localparam int N_MISMATCH = 10;
  // index past the register list, writes must be dropped
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] rel_x;
    logic signed [COORD_W-1:0] rel_y;
    logic signed [COORD_W-1:0] rel_z;
    logic signed [COORD_W-1:0] sensor_altitude;
    logic [CODE_W-1:0]         transponder_code;
  } target_t;

  typedef struct packed {
    logic [RNG_W-1:0]        target_range;
    logic signed [BRG_W-1:0] target_bearing;
    logic signed [ALT_W-1:0] target_altitude;
    logic [CODE_W-1:0]       contact_code;
  } contact_t;

  class contact_scoreboard;
    contact_t  expected_contacts[$];
    logic [HFOV_W-1:0] hfov;
    logic [VFOV_W-1:0] vfov;
    logic [RNG_W-1:0]  rlim;
    int n_targets, n_contacts, n_errors;

    function new();
      hfov = 17'd65536;
      vfov = 16'd32768;
      rlim = 24'd2560000;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        CFG_HFOV: hfov = data[HFOV_W-1:0];
        CFG_VFOV: vfov = data[VFOV_W-1:0];
        CFG_RLIM: rlim = data[RNG_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // vectoring rotation, accumulator in pi/2^23, rounded to pi/32768
    function longint polar_angle(longint xv, longint yv, longint acc);
      longint dx, dy;
      for (int i = 0; i < STAGES && i < TAB_N; i++) begin
        dx = yv >>> i;
        dy = xv >>> i;
        if (yv >= 0) begin
          xv += dx; yv -= dy; acc += longint'(ATAN_STEP[i]);
        end else begin
          xv -= dx; yv += dy; acc -= longint'(ATAN_STEP[i]);
        end
      end
      return (acc + 128) >>> 8;
    endfunction

    function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void note_target(target_t t);
      longint x, y, z, bx, by, tmp, acc, brg, elv, h, rng;
      longint unsigned hsq;
      contact_t c;
      x = t.rel_x; y = t.rel_y; z = t.rel_z;
      n_targets++;
      hsq = x * x + y * y;
      rng = int_sqrt(hsq + z * z);
      bx = x * 256; by = -y * 256; acc = 0;
      if (bx < 0) begin
        if (by >= 0) begin
          tmp = by; by = -bx; bx = tmp; acc = 64'sd1 << 22;
        end else begin
          tmp = -by; by = bx; bx = tmp; acc = -(64'sd1 << 22);
        end
      end
      brg = clip(polar_angle(bx, by, acc), 32768);
      h = int_sqrt(hsq << 16);
      elv = clip(polar_angle(h, z * 256, 0), 16384);
      if (rng == 0) return;
      if (2 * (brg < 0 ? -brg : brg) >= hfov) return;
      if (2 * (elv < 0 ? -elv : elv) >= vfov) return;
      if (rng >= rlim) return;
      c.target_range    = rng[RNG_W-1:0];
      c.target_bearing  = brg[BRG_W-1:0];
      c.target_altitude = ALT_W'(longint'(t.sensor_altitude) + z);
      c.contact_code    = t.transponder_code;
      expected_contacts.insert(expected_contacts.size(), c);
    endfunction

    function void check_contact(contact_t got);
      contact_t want;
      n_contacts++;
      if (expected_contacts.size() == 0) begin
        n_errors++;
        if (n_errors <= N_MISMATCH)
          $display("unexpected contact: %p", got);
        return;
      end
      want = expected_contacts.pop_front();
      if (got !== want) begin
        n_errors++;
        if (n_errors <= N_MISMATCH)
          $display("contact mismatch: expected %p, got %p", want, got);
      end
    endfunction

    function int pending();
      return expected_contacts.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  rcpg_in_if  in_item();
  rcpg_out_if out_item();

  radar_contact_polar_gate_unit #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst_n(rst_n), .in_item(in_item.sink), .out_item(out_item.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  contact_scoreboard sb = new();
  int gap_pct, stall_pct;
  int hold_seq, hold_seen, hold_left;
  int stuck;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_item.ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_LEN;
      out_item.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_item.ready <= 1'b0;
    end else begin
      out_item.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_item.valid && out_item.ready)
      sb.check_contact('{out_item.target_range, out_item.target_bearing,
                         out_item.target_altitude, out_item.contact_code});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_item.valid && in_item.ready) || (out_item.valid && out_item.ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STALL_MAX) begin
      $display("watchdog: no item moved for %0d cycles", STALL_MAX);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_target(target_t t);
    while ($urandom_range(99) < gap_pct) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.rel_x            <= t.rel_x;
    in_item.rel_y            <= t.rel_y;
    in_item.rel_z            <= t.rel_z;
    in_item.sensor_altitude  <= t.sensor_altitude;
    in_item.transponder_code <= t.transponder_code;
    in_item.valid            <= 1'b1;
    do @(posedge clk); while (!in_item.ready);
    sb.note_target(t);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic drain();
    in_item.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    // rejected items may still be in flight
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic target_t mk(int x, int y, int z, int alt, int code);
    target_t t;
    t.rel_x = COORD_W'(x); t.rel_y = COORD_W'(y); t.rel_z = COORD_W'(z);
    t.sensor_altitude = COORD_W'(alt); t.transponder_code = CODE_W'(code);
    return t;
  endfunction

  function automatic int near_val(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic target_t rand_target();
    target_t t;
    t.sensor_altitude  = COORD_W'($urandom);
    t.transponder_code = CODE_W'($urandom);
    case ($urandom_range(9))
      0, 1: begin
        t.rel_x = COORD_W'($urandom); t.rel_y = COORD_W'($urandom);
        t.rel_z = COORD_W'($urandom);
      end
      7: begin
        t.rel_x = COORD_W'(near_val(1 << 20)); t.rel_y = COORD_W'(near_val(1 << 20));
        t.rel_z = COORD_W'(near_val(1 << 16));
        if ($urandom_range(1)) t.rel_x = 0; else t.rel_y = 0;
      end
      8: begin
        t.rel_x = COORD_W'(near_val(3)); t.rel_y = COORD_W'(near_val(3));
        t.rel_z = COORD_W'(near_val(3));
      end
      default: begin
        t.rel_x = COORD_W'(near_val(1 << 21)); t.rel_y = COORD_W'(near_val(1 << 21));
        t.rel_z = COORD_W'(near_val(1 << 19));
      end
    endcase
    return t;
  endfunction

  task automatic random_targets(int n, bit with_hold);
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 3) hold_seq <= hold_seq + 1;
      send_target(rand_target());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_item.valid <= 1'b0;
    in_item.rel_x <= '0; in_item.rel_y <= '0; in_item.rel_z <= '0;
    in_item.sensor_altitude <= '0; in_item.transponder_code <= '0;
    cfg_we <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    hold_seq = 0;
    gap_pct = 12; stall_pct = 80;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: axes, quadrants, extremes, zero range, pass-through fields
    send_target(mk(0, 0, 0, 100, 16'h1234));
    send_target(mk(1000, 0, 0, 0, 0));
    send_target(mk(-1000, 0, 0, 0, 16'hFFFF));
    send_target(mk(0, 1000, 0, -5, 1));
    send_target(mk(0, -1000, 0, 5, 2));
    send_target(mk(-1000, 1000, 0, 0, 3));
    send_target(mk(-1000, -1000, 0, 0, 4));
    send_target(mk(1000, 1000, 1000, 0, 5));
    send_target(mk(0, 0, 1000, 0, 6));
    send_target(mk(0, 0, -1000, 0, 7));
    send_target(mk(1, 0, 0, -8388608, 8));
    send_target(mk(1, 0, -1, 8388607, 9));
    send_target(mk(1, 0, 1, 8388607, 10));
    send_target(mk(1, 0, -1, -8388608, 11));
    send_target(mk(-1, 0, 0, 0, 12));
    send_target(mk(-8388608, -8388608, -8388608, -8388608, 16'hFFFF));
    send_target(mk(8388607, 8388607, 8388607, 8388607, 16'hAAAA));
    send_target(mk(-8388608, 0, 0, 0, 16'h5555));
    send_target(mk(8388607, 0, 0, 0, 13));
    send_target(mk(2559999, 0, 0, 0, 14));
    send_target(mk(2560000, 0, 0, 0, 15));
    send_target(mk(-1, -1, 0, 0, 16));
    send_target(mk(-1, 1, 0, 0, 17));
    random_targets(160, 1'b0);
    drain();

    write_reg(CFG_RLIM, 24'hFFFFFF);
    write_reg(CFG_UNUSED, 24'h000001);
    random_targets(150, 1'b1);
    drain();

    gap_pct = 80; stall_pct = 12;
    write_reg(CFG_HFOV, 24'd16384);
    write_reg(CFG_VFOV, 24'd8192);
    write_reg(CFG_RLIM, 24'd1000000);
    random_targets(150, 1'b0);
    drain();

    write_reg(CFG_HFOV, 24'd0);
    write_reg(CFG_VFOV, 24'd0);
    write_reg(CFG_RLIM, 24'd0);
    random_targets(60, 1'b0);
    drain();

    gap_pct = 0; stall_pct = 0;
    write_reg(CFG_HFOV, 24'd32768);
    write_reg(CFG_VFOV, 24'd65535);
    write_reg(CFG_RLIM, 24'd8000000);
    random_targets(150, 1'b1);
    drain();

    write_reg(CFG_HFOV, 24'd65536);
    write_reg(CFG_VFOV, 24'd32768);
    write_reg(CFG_RLIM, 24'd2560000);
    random_targets(150, 1'b0);
    drain();

    $display("covered %0d targets, %0d contacts, six gate settings incl. closed and wide open",
             sb.n_targets, sb.n_contacts);
    $display("stall mixes: sender-heavy, receiver-heavy, none; %0d errors", sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
